// ===== rtl/lda_gibbs_topic_sampler_macros.svh =====
// Assertion macros shared by the checker of the topic sampler.
// Depends on nothing; the including module must have clk and rst in scope.
`ifndef LDA_GIBBS_TOPIC_SAMPLER_MACROS_SVH
`define LDA_GIBBS_TOPIC_SAMPLER_MACROS_SVH

// Checked only outside reset.
`define LGTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define LGTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lgts_pkg.sv =====
// Package of the LDA topic sampler: sizes, item types, codes and state enums.
// Used by every module of the block but lgts_ram; depends on nothing.
`default_nettype none

package lgts_pkg;

  localparam int NUM_TOPICS = 64;
  localparam int NUM_DOCS   = 1024;
  localparam int VOCAB_SIZE = 4096;
  localparam int COUNT_BITS = 20;
  localparam int TOTAL_BITS = 24;
  localparam int FRAC       = 16;

  localparam int PRIOR_W  = 24;
  localparam int VOCAB_W  = 13;
  localparam int TOPICS_W = 7;
  localparam int DOC_W    = 10;
  localparam int WORDID_W = 13;
  localparam int TOPIC_W  = 6;
  localparam int RAND_W   = 32;
  localparam int WGT_W    = 32;

  localparam int ZW = $clog2(NUM_TOPICS);
  localparam int KW = $clog2(NUM_TOPICS + 1);
  localparam int WW = $clog2(VOCAB_SIZE);

  localparam int DOC_DEPTH  = NUM_DOCS * NUM_TOPICS;
  localparam int WORD_DEPTH = NUM_TOPICS * VOCAB_SIZE;
  localparam int DTA_W      = $clog2(DOC_DEPTH);
  localparam int TWA_W      = $clog2(WORD_DEPTH);
  localparam int CLR_DEPTH  = (WORD_DEPTH > DOC_DEPTH) ?
                              ((WORD_DEPTH > NUM_TOPICS) ? WORD_DEPTH : NUM_TOPICS) :
                              ((DOC_DEPTH > NUM_TOPICS) ? DOC_DEPTH : NUM_TOPICS);
  localparam int CLR_W      = $clog2(CLR_DEPTH);

  // Operand widths of one weight: A and B in Q.16, D in Q.16, product of A and B.
  localparam int VB_W  = VOCAB_W + PRIOR_W;
  localparam int OPW   = COUNT_BITS + FRAC + 1;
  localparam int DW    = TOTAL_BITS + FRAC + 1;
  localparam int PW    = 2 * OPW;
  localparam int HLW   = (OPW + 1) / 2;
  localparam int DCNT_W = $clog2(WGT_W);

  // Sum of all weights and the threshold product.
  localparam int TW    = WGT_W + ZW;
  localparam int TLW   = (TW + 1) / 2;
  localparam int THR_W = RAND_W + TW;

  localparam logic FUNC_ASSIGN   = 1'b0;
  localparam logic FUNC_RESAMPLE = 1'b1;
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef enum logic [1:0] {
    REG_ALPHA,
    REG_BETA,
    REG_VOCAB,
    REG_TOPICS
  } reg_idx_t;

  typedef struct packed {
    logic                func;
    logic [DOC_W-1:0]    doc_index;
    logic [WORDID_W-1:0] word_id;
    logic [TOPIC_W-1:0]  old_topic;
    logic [RAND_W-1:0]   random_u;
  } in_item_t;

  typedef struct packed {
    logic [TOPIC_W-1:0] new_topic;
    logic               status;
  } out_item_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] doc_cnt;
    logic [COUNT_BITS-1:0] word_cnt;
    logic [TOTAL_BITS-1:0] tot_cnt;
    logic [PRIOR_W-1:0]    alpha;
    logic [PRIOR_W-1:0]    beta;
    logic [VB_W-1:0]       vbeta;
  } wgt_req_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_OLD_CHK,
    S_SCAN_RD,
    S_SCAN_LOAD,
    S_SCAN_WAIT,
    S_THR0,
    S_THR1,
    S_PICK_RD,
    S_PICK_CHK,
    S_ADD_RD,
    S_ADD_WR,
    S_FIN
  } seq_state_t;

  typedef enum logic [1:0] {
    W_IDLE,
    W_MUL,
    W_SAT,
    W_DIV
  } wgt_state_t;

endpackage

`default_nettype wire

// ===== rtl/lgts_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
`default_nettype none

module lgts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lgts_weight.sv =====
// Weight unit: floor(A*B/D) saturated to 32 bits, by partial products and a
// restoring division that yields one quotient bit per cycle. Uses lgts_pkg.
`default_nettype none

module lgts_weight (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  lgts_pkg::wgt_req_t        req,
  output logic                      done,
  output logic [lgts_pkg::WGT_W-1:0] weight
);

  localparam int OPW  = lgts_pkg::OPW;
  localparam int DW   = lgts_pkg::DW;
  localparam int PW   = lgts_pkg::PW;
  localparam int HLW  = lgts_pkg::HLW;
  localparam int WGT_W = lgts_pkg::WGT_W;
  localparam int CW   = lgts_pkg::DCNT_W;

  lgts_pkg::wgt_state_t state, state_next;

  logic [OPW-1:0]   a_op, b_op;
  logic [DW-1:0]    d_op;
  logic [PW-1:0]    acc;
  logic [DW-1:0]    rem;
  logic [WGT_W-1:0] qlo;
  logic [CW-1:0]    cnt;

  logic [OPW-1:0]   a_in, b_in;
  logic [DW-1:0]    d_in;
  logic [HLW-1:0]   ah, bh;
  logic [2*HLW-1:0] pp;
  logic [PW-1:0]    pp_sh;
  logic [DW:0]      rem2;
  logic             ge;
  logic             sat;
  logic             mul_last, div_last;

  assign a_in = OPW'(req.alpha) + (OPW'(req.doc_cnt) << lgts_pkg::FRAC);
  assign b_in = OPW'(req.beta) + (OPW'(req.word_cnt) << lgts_pkg::FRAC);
  assign d_in = (DW'(req.tot_cnt) << lgts_pkg::FRAC) + DW'(req.vbeta);

  // Step 0 takes low by low, steps 1 and 2 the cross terms, step 3 high by high.
  assign ah = cnt[1] ? HLW'(a_op >> HLW) : a_op[HLW-1:0];
  assign bh = cnt[0] ? HLW'(b_op >> HLW) : b_op[HLW-1:0];
  assign pp = ah * bh;

  always_comb begin
    case (cnt[1:0])
      2'd0:    pp_sh = PW'(pp);
      2'd3:    pp_sh = PW'(pp) << (2 * HLW);
      default: pp_sh = PW'(pp) << HLW;
    endcase
  end

  // The quotient needs more than 32 bits exactly when the upper part reaches D.
  assign sat  = (acc >> WGT_W) >= PW'(d_op);
  assign rem2 = {rem, qlo[WGT_W-1]};
  assign ge   = rem2 >= {1'b0, d_op};

  always_comb begin
    case (state)
      lgts_pkg::W_IDLE:  state_next = start ? lgts_pkg::W_MUL : lgts_pkg::W_IDLE;
      lgts_pkg::W_MUL:   state_next = mul_last ? lgts_pkg::W_SAT : lgts_pkg::W_MUL;
      lgts_pkg::W_SAT:   state_next = sat ? lgts_pkg::W_IDLE : lgts_pkg::W_DIV;
      lgts_pkg::W_DIV:   state_next = div_last ? lgts_pkg::W_IDLE : lgts_pkg::W_DIV;
      default: state_next = lgts_pkg::W_IDLE;
    endcase
  end

  always_comb begin
    mul_last = 1'b0;
    div_last = 1'b0;
    case (state)
      lgts_pkg::W_MUL:   mul_last = (cnt[1:0] == 2'd3);
      lgts_pkg::W_DIV:   div_last = (cnt == '0);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lgts_pkg::W_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= ((state == lgts_pkg::W_SAT) && sat) || div_last;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      lgts_pkg::W_IDLE: begin
        a_op <= a_in;
        b_op <= b_in;
        d_op <= d_in;
        acc  <= '0;
        cnt  <= '0;
      end
      lgts_pkg::W_MUL: begin
        acc <= acc + pp_sh;
        cnt <= cnt + CW'(1);
      end
      lgts_pkg::W_SAT: begin
        rem <= DW'(acc >> WGT_W);
        qlo <= acc[WGT_W-1:0];
        cnt <= CW'(WGT_W - 1);
        if (sat) begin
          weight <= '1;
        end
      end
      lgts_pkg::W_DIV: begin
        rem <= ge ? DW'(rem2 - {1'b0, d_op}) : rem2[DW-1:0];
        qlo <= {qlo[WGT_W-2:0], ge};
        cnt <= cnt - CW'(1);
        if (div_last) begin
          weight <= {qlo[WGT_W-2:0], ge};
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/lda_gibbs_topic_sampler.sv =====
// Top level of the LDA collapsed Gibbs topic sampler: sequencer, count RAMs,
// weight RAM and configuration. Uses lgts_pkg, lgts_ram and lgts_weight.
//
//   channel  signals                        moves
//   -------  -----------------------------  ---------------------------------
//   in       in_valid, in_stall, in_item    one token per item
//   out      out_valid, out_stall, out_item one result per token
//   cfg      cfg_we, cfg_index, cfg_data    register write, no wait
//
// A resample computes the weight of each of the K topics in use: the weight
// unit spends 4 multiply steps per topic and, unless the weight saturates, 32
// division steps; the draw then reads the weight RAM back topic by topic.
// After reset the count RAMs are cleared one entry a cycle, through every
// address of the largest RAM, while in_stall stays high. A finished result
// waits in the output register.
`default_nettype none

module lda_gibbs_topic_sampler (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  lgts_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output lgts_pkg::out_item_t                 out_item,
  input  logic                                cfg_we,
  input  lgts_pkg::reg_idx_t                  cfg_index,
  input  logic [lgts_pkg::PRIOR_W-1:0]        cfg_data
);

  localparam int CB    = lgts_pkg::COUNT_BITS;
  localparam int TB    = lgts_pkg::TOTAL_BITS;
  localparam int ZW    = lgts_pkg::ZW;
  localparam int KW    = lgts_pkg::KW;
  localparam int WW    = lgts_pkg::WW;
  localparam int TW    = lgts_pkg::TW;
  localparam int TLW   = lgts_pkg::TLW;
  localparam int THR_W = lgts_pkg::THR_W;
  localparam int WGT_W = lgts_pkg::WGT_W;
  localparam int RAND_W = lgts_pkg::RAND_W;
  localparam int CLR_W = lgts_pkg::CLR_W;
  localparam int DTA_W = lgts_pkg::DTA_W;
  localparam int TWA_W = lgts_pkg::TWA_W;

  lgts_pkg::seq_state_t state, state_next;

  // Configuration registers.
  logic [lgts_pkg::PRIOR_W-1:0]  alpha_q, beta_q;
  logic [lgts_pkg::VOCAB_W-1:0]  vocab_in_use;
  logic [lgts_pkg::TOPICS_W-1:0] topics_in_use;

  // Item context.
  lgts_pkg::in_item_t        item;
  logic [ZW-1:0]             newz;
  logic                      status;
  logic [KW-1:0]             k_eff;
  logic [lgts_pkg::PRIOR_W-1:0] beta_eff;
  logic [lgts_pkg::VB_W-1:0] vbeta;
  logic [ZW-1:0]             z;
  logic [TW-1:0]             total, run;
  logic [THR_W-1:0]          thr_acc;
  logic [CLR_W-1:0]          clr_cnt;

  // Combinational helpers.
  logic [KW-1:0]             k_c;
  logic [lgts_pkg::VOCAB_W-1:0] vocab_c;
  logic [lgts_pkg::PRIOR_W-1:0] beta_c;
  logic [ZW-1:0]             klast;
  logic [WW-1:0]             w;
  logic                      bad;
  logic [ZW-1:0]             zs;
  logic                      any_zero;
  logic                      z_last;
  logic [TW-1:0]             run_next;
  logic                      hit;
  logic [RAND_W+KW-1:0]      uprod;
  logic [KW-1:0]             uz;
  logic [ZW-1:0]             unif_z;
  logic [RAND_W+TLW-1:0]     thr_lo;
  logic [RAND_W+TW-TLW-1:0]  thr_hi;
  logic                      fin_load;

  // Memory ports.
  logic                      cnt_re, cnt_we, clearing, dec_wr;
  logic                      doc_we, word_we, tot_we;
  logic [DTA_W-1:0]          doc_raddr, doc_waddr;
  logic [TWA_W-1:0]          word_raddr, word_waddr;
  logic [ZW-1:0]             tot_waddr;
  logic [CB-1:0]             doc_rdata, word_rdata, doc_wdata, word_wdata;
  logic [TB-1:0]             tot_rdata, tot_wdata;
  logic                      wgt_we, wgt_re, wgt_start, wgt_done;
  logic [WGT_W-1:0]          wgt_rdata, weight;
  lgts_pkg::wgt_req_t        wgt_req;

  // A zero topic count, vocabulary size or beta acts as one; a topic count above NUM_TOPICS acts as NUM_TOPICS.
  always_comb begin
    if (topics_in_use == '0) begin
      k_c = KW'(1);
    end else if (topics_in_use > lgts_pkg::TOPICS_W'(lgts_pkg::NUM_TOPICS)) begin
      k_c = KW'(lgts_pkg::NUM_TOPICS);
    end else begin
      k_c = KW'(topics_in_use);
    end
  end
  assign vocab_c = (vocab_in_use == '0) ? lgts_pkg::VOCAB_W'(1) : vocab_in_use;
  assign beta_c  = (beta_q == '0) ? lgts_pkg::PRIOR_W'(1) : beta_q;

  assign klast = ZW'(k_eff - KW'(1));
  assign w     = WW'(item.word_id - lgts_pkg::WORDID_W'(1));
  assign bad   = (item.doc_index >= lgts_pkg::NUM_DOCS) || (item.word_id == '0) ||
                 (item.word_id > lgts_pkg::VOCAB_SIZE) || ({1'b0, item.old_topic} >= k_c);

  assign any_zero = (doc_rdata == '0) || (word_rdata == '0) || (tot_rdata == '0);
  assign z_last   = (z == klast);
  assign run_next = run + TW'(wgt_rdata);
  assign hit      = run_next > thr_acc[THR_W-1:WGT_W];

  assign uprod  = item.random_u * k_eff;
  assign uz     = uprod[RAND_W+KW-1:RAND_W];
  assign unif_z = (uz >= k_eff) ? klast : ZW'(uz);

  assign thr_lo = item.random_u * total[TLW-1:0];
  assign thr_hi = item.random_u * total[TW-1:TLW];

  assign fin_load = (state == lgts_pkg::S_FIN) && (!out_valid || !out_stall);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      lgts_pkg::S_CLEAR: begin
        if (clr_cnt == CLR_W'(lgts_pkg::CLR_DEPTH - 1)) state_next = lgts_pkg::S_IDLE;
      end
      lgts_pkg::S_IDLE:      if (in_valid) state_next = lgts_pkg::S_CHECK;
      lgts_pkg::S_CHECK: begin
        if (bad) begin
          state_next = lgts_pkg::S_FIN;
        end else if (item.func == lgts_pkg::FUNC_ASSIGN) begin
          state_next = lgts_pkg::S_ADD_WR;
        end else begin
          state_next = lgts_pkg::S_OLD_CHK;
        end
      end
      lgts_pkg::S_OLD_CHK:   state_next = any_zero ? lgts_pkg::S_FIN : lgts_pkg::S_SCAN_RD;
      lgts_pkg::S_SCAN_RD:   state_next = lgts_pkg::S_SCAN_LOAD;
      lgts_pkg::S_SCAN_LOAD: state_next = lgts_pkg::S_SCAN_WAIT;
      lgts_pkg::S_SCAN_WAIT: begin
        if (wgt_done) begin
          state_next = z_last ? lgts_pkg::S_THR0 : lgts_pkg::S_SCAN_RD;
        end
      end
      lgts_pkg::S_THR0:      state_next = (total == '0) ? lgts_pkg::S_ADD_RD : lgts_pkg::S_THR1;
      lgts_pkg::S_THR1:      state_next = lgts_pkg::S_PICK_RD;
      lgts_pkg::S_PICK_RD:   state_next = lgts_pkg::S_PICK_CHK;
      lgts_pkg::S_PICK_CHK: begin
        state_next = (hit || z_last) ? lgts_pkg::S_ADD_RD : lgts_pkg::S_PICK_RD;
      end
      lgts_pkg::S_ADD_RD:    state_next = lgts_pkg::S_ADD_WR;
      lgts_pkg::S_ADD_WR:    state_next = lgts_pkg::S_FIN;
      lgts_pkg::S_FIN:       if (!out_valid || !out_stall) state_next = lgts_pkg::S_IDLE;
      default:     state_next = lgts_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_stall  = 1'b1;
    cnt_re    = 1'b0;
    cnt_we    = 1'b0;
    clearing  = 1'b0;
    dec_wr    = 1'b0;
    zs        = newz;
    wgt_start = 1'b0;
    wgt_we    = 1'b0;
    wgt_re    = 1'b0;
    case (state)
      lgts_pkg::S_CLEAR:     clearing = 1'b1;
      lgts_pkg::S_IDLE:      in_stall = 1'b0;
      lgts_pkg::S_CHECK:     cnt_re = 1'b1;
      lgts_pkg::S_OLD_CHK: begin
        cnt_we = !any_zero;
        dec_wr = 1'b1;
      end
      lgts_pkg::S_SCAN_RD: begin
        cnt_re = 1'b1;
        zs     = z;
      end
      lgts_pkg::S_SCAN_LOAD: wgt_start = 1'b1;
      lgts_pkg::S_SCAN_WAIT: wgt_we = wgt_done;
      lgts_pkg::S_PICK_RD:   wgt_re = 1'b1;
      lgts_pkg::S_ADD_RD:    cnt_re = 1'b1;
      lgts_pkg::S_ADD_WR:    cnt_we = 1'b1;
      default: ;
    endcase
  end

  // Count RAM addressing and write data.
  assign doc_raddr  = DTA_W'(item.doc_index * lgts_pkg::NUM_TOPICS + zs);
  assign word_raddr = TWA_W'(zs * lgts_pkg::VOCAB_SIZE + w);

  always_comb begin
    if (clearing) begin
      doc_waddr  = clr_cnt[DTA_W-1:0];
      word_waddr = clr_cnt[TWA_W-1:0];
      tot_waddr  = clr_cnt[ZW-1:0];
      doc_wdata  = '0;
      word_wdata = '0;
      tot_wdata  = '0;
      doc_we     = clr_cnt < lgts_pkg::DOC_DEPTH;
      word_we    = clr_cnt < lgts_pkg::WORD_DEPTH;
      tot_we     = clr_cnt < lgts_pkg::NUM_TOPICS;
    end else begin
      doc_waddr  = DTA_W'(item.doc_index * lgts_pkg::NUM_TOPICS + newz);
      word_waddr = TWA_W'(newz * lgts_pkg::VOCAB_SIZE + w);
      tot_waddr  = newz;
      doc_we     = cnt_we;
      word_we    = cnt_we;
      tot_we     = cnt_we;
      if (dec_wr) begin
        doc_wdata  = doc_rdata - CB'(1);
        word_wdata = word_rdata - CB'(1);
        tot_wdata  = tot_rdata - TB'(1);
      end else begin
        // Increments saturate at the top of each count's width.
        doc_wdata  = (doc_rdata == '1) ? doc_rdata : doc_rdata + CB'(1);
        word_wdata = (word_rdata == '1) ? word_rdata : word_rdata + CB'(1);
        tot_wdata  = (tot_rdata == '1) ? tot_rdata : tot_rdata + TB'(1);
      end
    end
  end

  lgts_ram #(.WIDTH(CB), .DEPTH(lgts_pkg::DOC_DEPTH)) u_doc_ram (
    .clk   (clk),
    .we    (doc_we),
    .waddr (doc_waddr),
    .wdata (doc_wdata),
    .re    (cnt_re),
    .raddr (doc_raddr),
    .rdata (doc_rdata)
  );

  lgts_ram #(.WIDTH(CB), .DEPTH(lgts_pkg::WORD_DEPTH)) u_word_ram (
    .clk   (clk),
    .we    (word_we),
    .waddr (word_waddr),
    .wdata (word_wdata),
    .re    (cnt_re),
    .raddr (word_raddr),
    .rdata (word_rdata)
  );

  lgts_ram #(.WIDTH(TB), .DEPTH(lgts_pkg::NUM_TOPICS)) u_tot_ram (
    .clk   (clk),
    .we    (tot_we),
    .waddr (tot_waddr),
    .wdata (tot_wdata),
    .re    (cnt_re),
    .raddr (zs),
    .rdata (tot_rdata)
  );

  lgts_ram #(.WIDTH(WGT_W), .DEPTH(lgts_pkg::NUM_TOPICS)) u_wgt_ram (
    .clk   (clk),
    .we    (wgt_we),
    .waddr (z),
    .wdata (weight),
    .re    (wgt_re),
    .raddr (z),
    .rdata (wgt_rdata)
  );

  assign wgt_req.doc_cnt  = doc_rdata;
  assign wgt_req.word_cnt = word_rdata;
  assign wgt_req.tot_cnt  = tot_rdata;
  assign wgt_req.alpha    = alpha_q;
  assign wgt_req.beta     = beta_eff;
  assign wgt_req.vbeta    = vbeta;

  lgts_weight u_weight (
    .clk    (clk),
    .rst    (rst),
    .start  (wgt_start),
    .req    (wgt_req),
    .done   (wgt_done),
    .weight (weight)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= lgts_pkg::S_CLEAR;
      clr_cnt       <= '0;
      out_valid     <= 1'b0;
      alpha_q       <= lgts_pkg::PRIOR_W'(8192);
      beta_q        <= lgts_pkg::PRIOR_W'(6554);
      vocab_in_use  <= lgts_pkg::VOCAB_W'(4096);
      topics_in_use <= lgts_pkg::TOPICS_W'(64);
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_cnt <= clr_cnt + CLR_W'(1);
      end
      if (fin_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          lgts_pkg::REG_ALPHA:  alpha_q       <= cfg_data;
          lgts_pkg::REG_BETA:   beta_q        <= cfg_data;
          lgts_pkg::REG_VOCAB:  vocab_in_use  <= cfg_data[lgts_pkg::VOCAB_W-1:0];
          lgts_pkg::REG_TOPICS: topics_in_use <= cfg_data[lgts_pkg::TOPICS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      lgts_pkg::S_IDLE: begin
        if (in_valid) begin
          item <= in_item;
          newz <= ZW'(in_item.old_topic);
        end
      end
      lgts_pkg::S_CHECK: begin
        k_eff    <= k_c;
        beta_eff <= beta_c;
        vbeta    <= vocab_c * beta_c;
        status   <= bad ? lgts_pkg::STATUS_REJECT : lgts_pkg::STATUS_OK;
        z        <= '0;
        total    <= '0;
      end
      lgts_pkg::S_OLD_CHK: begin
        if (any_zero) begin
          status <= lgts_pkg::STATUS_REJECT;
        end
      end
      lgts_pkg::S_SCAN_WAIT: begin
        if (wgt_done) begin
          total <= total + TW'(weight);
          z     <= z + ZW'(1);
        end
      end
      lgts_pkg::S_THR0: begin
        thr_acc <= THR_W'(thr_lo);
        z       <= '0;
        run     <= '0;
        // With every weight zero the draw is uniform over the topics.
        if (total == '0) begin
          newz <= unif_z;
        end
      end
      lgts_pkg::S_THR1: thr_acc <= thr_acc + (THR_W'(thr_hi) << TLW);
      lgts_pkg::S_PICK_CHK: begin
        run <= run_next;
        z   <= z + ZW'(1);
        if (hit || z_last) begin
          newz <= z;
        end
      end
      lgts_pkg::S_FIN: begin
        if (fin_load) begin
          out_item.new_topic <= lgts_pkg::TOPIC_W'(newz);
          out_item.status    <= status;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/lgts_checker.sv =====
// Port-level checker of the topic sampler, bound to the top level.
// Depends on lgts_pkg and lda_gibbs_topic_sampler_macros.svh.
`default_nettype none

`include "lda_gibbs_topic_sampler_macros.svh"

module lgts_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire lgts_pkg::out_item_t out_item
);

  // A result that is held back stays as it was.
  `LGTS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_item), "stalled result changed")

  // Reset empties the output register.
  `LGTS_ASSERT_ALWAYS(a_rst_out, rst |=> !out_valid, "result present after reset")

  // The count tables are cleared after reset before any item is taken.
  `LGTS_ASSERT_ALWAYS(a_rst_stall, rst |=> in_stall, "input taken during clearing")

  // One item at a time: taking an item closes the input for the next cycle.
  `LGTS_ASSERT(a_one_item, in_valid && !in_stall |=> in_stall, "second item taken while busy")

endmodule

bind lda_gibbs_topic_sampler lgts_checker u_lgts_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire
